/* hw/rtl/nnr_pkg.sv */
`timescale 1ns / 1ps
package nnr_pkg;
  localparam int FRAC_BITS = 16;
  localparam int MAX_DEGREE = 16;
  localparam int MIN_DEGREE = 2;
  localparam int MAX_ITER = 100;
  localparam int DEG_W = 5;
  localparam int ITER_W = 7;
  localparam int DATA_W = 32;
  localparam int POW_W = 64;
  localparam int DIV_W = DATA_W + FRAC_BITS;
  localparam int SUM_W = DIV_W + 6;
  localparam logic CFG_DEGREE = 1'b0;
  localparam logic CFG_ITER = 1'b1;

  typedef struct packed {
    logic load;
    logic pow_init;
    logic pow_step;
    logic qdiv_start;
    logic ndiv_start;
    logic update;
  } nnr_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic pow_zero;
  } nnr_stat_t;
endpackage

/* hw/rtl/newton_nth_root.sv */
`timescale 1ns / 1ps
// Newton n-th root of an unsigned Q16.16 word.
// Input channel: radicand with valid/ready; a word is taken when both high.
// Output channel: root_value and status with valid/ready.
// Config channel: cfg_index 0 = degree (2..16), 1 = iteration count (0..100).
// Each Newton step runs n-1 multiplies (one per cycle, 32x32 partials),
// then, unless the power is zero, two passes of a shared radix-2 divider.
// A zero radicand or an iteration count of 0 goes straight to the output.
// One word is in flight at a time; in_ready is high only when idle.
// The result is held in the output register until taken; a stalled receiver
// stalls the block. Reset sets degree 2, iteration count 100 and clears
// all control state.
module newton_nth_root (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] radicand,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] root_value,
  output logic        status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import nnr_pkg::*;

  logic [DEG_W-1:0] root_degree;
  logic [ITER_W-1:0] iteration_count;
  logic [DEG_W-1:0] deg_eff;
  logic [ITER_W-1:0] iter_eff;
  nnr_cmd_t cmd;
  nnr_stat_t stat;
  logic idle, done, zero_out, clamp;
  logic [DATA_W-1:0] est;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      root_degree <= DEG_W'(2);
      iteration_count <= ITER_W'(MAX_ITER);
    end else if (cfg_valid && cfg_index[7:1] == '0) begin
      if (cfg_index[0] == CFG_DEGREE) root_degree <= cfg_data[DEG_W-1:0];
      else if (cfg_index[0] == CFG_ITER) iteration_count <= cfg_data[ITER_W-1:0];
    end
  end

  assign deg_eff = (root_degree < DEG_W'(MIN_DEGREE)) ? DEG_W'(MIN_DEGREE) :
                   (root_degree > DEG_W'(MAX_DEGREE)) ? DEG_W'(MAX_DEGREE) : root_degree;
  assign iter_eff = (iteration_count > ITER_W'(MAX_ITER)) ? ITER_W'(MAX_ITER)
                                                          : iteration_count;

  assign in_ready = idle;

  nnr_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_go(in_valid && idle), .c_zero(radicand == '0),
    .degree(deg_eff), .iters(iter_eff), .stat(stat), .out_take(out_ready),
    .cmd(cmd), .idle(idle), .done(done), .zero_out(zero_out)
  );

  nnr_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .radicand(radicand), .degree(deg_eff),
    .stat(stat), .estimate(est), .clamp_flag(clamp)
  );

  assign out_valid = done;
  assign root_value = zero_out ? '0 : est;
  assign status = zero_out ? 1'b0 : clamp;
endmodule

/* hw/rtl/nnr_div.sv */
`timescale 1ns / 1ps
module nnr_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [nnr_pkg::SUM_W-1:0]  dividend,
  input  logic [nnr_pkg::POW_W-1:0]  divisor,
  output logic                       busy,
  output logic [nnr_pkg::SUM_W-1:0]  quotient
);
  import nnr_pkg::*;
  localparam int CNT_W = $clog2(SUM_W + 1);

  logic [SUM_W-1:0] dvd;
  logic [POW_W:0] rem;
  logic [POW_W-1:0] dvs;
  logic [CNT_W-1:0] cnt;
  logic [POW_W:0] rem_sh;
  logic [POW_W:0] diff;

  assign rem_sh = {rem[POW_W-1:0], dvd[SUM_W-1]};
  assign diff = rem_sh - {1'b0, dvs};
  assign quotient = dvd;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= CNT_W'(SUM_W);
      dvd <= dividend;
      dvs <= divisor;
      rem <= '0;
    end else if (busy) begin
      if (diff[POW_W]) begin
        rem <= rem_sh;
        dvd <= {dvd[SUM_W-2:0], 1'b0};
      end else begin
        rem <= diff;
        dvd <= {dvd[SUM_W-2:0], 1'b1};
      end
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) busy <= 1'b0;
    end
  end
endmodule

/* hw/rtl/nnr_datapath.sv */
`timescale 1ns / 1ps
module nnr_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  nnr_pkg::nnr_cmd_t           cmd,
  input  logic [nnr_pkg::DATA_W-1:0]  radicand,
  input  logic [nnr_pkg::DEG_W-1:0]   degree,
  output nnr_pkg::nnr_stat_t          stat,
  output logic [nnr_pkg::DATA_W-1:0]  estimate,
  output logic                        clamp_flag
);
  import nnr_pkg::*;

  logic [DATA_W-1:0] c_reg;
  logic [POW_W-1:0] power_accumulator;
  logic [SUM_W-1:0] q_val;
  logic [SUM_W-1:0] div_a;
  logic [POW_W-1:0] div_b;
  logic [SUM_W-1:0] div_q;
  logic div_busy;
  logic [POW_W-1:0] lo_prod;
  logic [POW_W-1:0] hi_prod;
  logic [POW_W:0] mul_sum;
  logic mul_ovf;
  logic [SUM_W-1:0] sum_val;
  logic q_grab;
  logic busy_d;
  logic phase_n;

  // p*x split in two 32x32 products
  assign lo_prod = (power_accumulator[31:0] * estimate) >> FRAC_BITS;
  assign hi_prod = power_accumulator[63:32] * estimate;
  assign mul_sum = {1'b0, hi_prod[POW_W-1-(32-FRAC_BITS):0], {(32-FRAC_BITS){1'b0}}}
                   + {1'b0, lo_prod};
  assign mul_ovf = (hi_prod[POW_W-1:32+FRAC_BITS] != '0) || mul_sum[POW_W];

  assign sum_val = SUM_W'((DEG_W + DATA_W)'(degree - 1'b1) * estimate) + q_val;

  always_comb begin
    if (cmd.ndiv_start) begin
      div_a = sum_val;
      div_b = POW_W'(degree);
    end else begin
      div_a = SUM_W'({c_reg, {FRAC_BITS{1'b0}}});
      div_b = power_accumulator;
    end
  end

  nnr_div u_div (
    .clk(clk), .rst(rst), .start(cmd.qdiv_start | cmd.ndiv_start),
    .dividend(div_a), .divisor(div_b), .busy(div_busy), .quotient(div_q)
  );

  assign stat.div_busy = div_busy;
  assign stat.pow_zero = (power_accumulator == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      clamp_flag <= 1'b0;
      estimate <= '0;
      power_accumulator <= '0;
    end else begin
      if (cmd.load) begin
        c_reg <= radicand;
        estimate <= radicand >> 1;
        clamp_flag <= 1'b0;
      end
      if (cmd.pow_init) power_accumulator <= POW_W'(1) << FRAC_BITS;
      if (cmd.pow_step) begin
        if (mul_ovf) begin
          power_accumulator <= '1;
          clamp_flag <= 1'b1;
        end else begin
          power_accumulator <= mul_sum[POW_W-1:0];
        end
      end
      if (cmd.update) begin
        if (power_accumulator == '0) begin
          estimate <= '1;
          clamp_flag <= 1'b1;
        end else if (div_q[SUM_W-1:DATA_W] != '0) begin
          estimate <= '1;
          clamp_flag <= 1'b1;
        end else begin
          estimate <= div_q[DATA_W-1:0];
        end
      end
    end
  end

  // quotient c/p captured when divider finishes its first pass
  always_ff @(posedge clk) begin
    if (rst) begin
      busy_d <= 1'b0;
      phase_n <= 1'b0;
    end else begin
      busy_d <= div_busy;
      if (cmd.qdiv_start) phase_n <= 1'b0;
      if (cmd.ndiv_start) phase_n <= 1'b1;
    end
  end
  assign q_grab = busy_d && !div_busy && !phase_n;
  always_ff @(posedge clk) begin
    if (q_grab) q_val <= div_q;
  end
endmodule

/* hw/rtl/nnr_ctrl.sv */
`timescale 1ns / 1ps
module nnr_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_go,
  input  logic                        c_zero,
  input  logic [nnr_pkg::DEG_W-1:0]   degree,
  input  logic [nnr_pkg::ITER_W-1:0]  iters,
  input  nnr_pkg::nnr_stat_t          stat,
  input  logic                        out_take,
  output nnr_pkg::nnr_cmd_t           cmd,
  output logic                        idle,
  output logic                        done,
  output logic                        zero_out
);
  import nnr_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_POW, S_QDIV, S_QWAIT, S_NDIV, S_NWAIT, S_UPD, S_OUT
  } state_t;

  state_t state;
  logic [ITER_W-1:0] step_counter;
  logic [DEG_W-1:0] k;

  assign idle = (state == S_IDLE);
  assign done = (state == S_OUT);

  always_comb begin
    cmd = '0;
    case (state)
      S_IDLE: begin
        cmd.load = in_go;
        cmd.pow_init = in_go;
      end
      S_POW: cmd.pow_step = (k < degree);
      S_QDIV: cmd.qdiv_start = !stat.pow_zero;
      S_NDIV: cmd.ndiv_start = 1'b1;
      S_UPD: begin
        cmd.update = 1'b1;
        cmd.pow_init = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step_counter <= '0;
      k <= '0;
      zero_out <= 1'b0;
    end else begin
      case (state)
        S_IDLE: if (in_go) begin
          step_counter <= '0;
          k <= DEG_W'(1);
          zero_out <= c_zero;
          state <= (c_zero || iters == '0) ? S_OUT : S_POW;
        end
        S_POW: if (k < degree) k <= k + 1'b1;
               else state <= S_QDIV;
        S_QDIV: state <= stat.pow_zero ? S_UPD : S_QWAIT;
        S_QWAIT: if (!stat.div_busy) state <= S_NDIV;
        S_NDIV: state <= S_NWAIT;
        S_NWAIT: if (!stat.div_busy) state <= S_UPD;
        S_UPD: begin
          k <= DEG_W'(1);
          step_counter <= step_counter + 1'b1;
          state <= (step_counter + 1'b1 == iters) ? S_OUT : S_POW;
        end
        S_OUT: if (out_take) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

/* hw/rtl/nnr_checker.sv */
`timescale 1ns / 1ps
module nnr_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [31:0] root_value,
  input logic status
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(root_value) && $stable(status))
    else $error("output dropped while stalled");
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("ready while result pending");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted second word");
endmodule

bind newton_nth_root nnr_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .root_value(root_value),
  .status(status)
);

/* test/newton_nth_root_tb.sv */
`timescale 1ns / 1ps
module newton_nth_root_tb;
  import nnr_pkg::*;

  localparam logic [7:0] IDX_DEGREE = {7'd0, CFG_DEGREE};
  localparam logic [7:0] IDX_ITER = {7'd0, CFG_ITER};
  localparam logic [7:0] IDX_UNUSED = 8'd200;
  localparam logic [31:0] ROOT_MAX = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {K_DATA, K_CFG, K_DRAIN} kind_t;
  typedef struct {
    kind_t kind;
    logic [7:0] idx;
    logic [31:0] val;
  } req_t;
  typedef struct {
    logic [31:0] root;
    logic status;
  } root_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [31:0] radicand = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [31:0] root_value;
  logic status;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [7:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  req_t pending[$];
  root_t expected_roots[$];
  logic [DEG_W-1:0] degree_sh = 5'd2;
  logic [ITER_W-1:0] iters_sh = 7'd100;
  int errors = 0;
  int pause_cnt = 0;
  int results_seen = 0;
  int hold_cnt = 0;
  bit hold_done = 0;
  int words_sent = 0;

  newton_nth_root dut (.*);

  always #2 clk = ~clk;

  function automatic root_t predict_root(logic [31:0] c);
    root_t r;
    logic [63:0] n, x, p, q, s, nx;
    logic [127:0] prod;
    int iters;
    r.status = 1'b0;
    n = 64'(degree_sh);
    if (n < 64'(MIN_DEGREE)) n = 64'(MIN_DEGREE);
    if (n > 64'(MAX_DEGREE)) n = 64'(MAX_DEGREE);
    iters = iters_sh > ITER_W'(MAX_ITER) ? MAX_ITER : int'(iters_sh);
    if (c == 0) begin
      r.root = '0;
      return r;
    end
    x = {32'd0, c} >> 1;
    for (int i = 0; i < iters; i++) begin
      p = 64'd1 << FRAC_BITS;
      for (int k = 1; k < n; k++) begin
        prod = ({64'd0, p} * {64'd0, x}) >> FRAC_BITS;
        if (prod[127:64] != 0) begin
          p = '1;
          r.status = 1'b1;
        end else begin
          p = prod[63:0];
        end
      end
      if (p == 0) begin
        x = {32'd0, ROOT_MAX};
        r.status = 1'b1;
      end else begin
        q = ({16'd0, c, 16'd0}) / p;
        s = (n - 1) * x + q;
        nx = s / n;
        if (nx > {32'd0, ROOT_MAX}) begin
          nx = {32'd0, ROOT_MAX};
          r.status = 1'b1;
        end
        x = nx;
      end
    end
    r.root = x[31:0];
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    logic v_n, c_n;
    bit quiet;
    req_t h;
    if (!rst) begin
      v_n = in_valid;
      c_n = cfg_valid;
      quiet = words_sent >= 70 && words_sent < 100;
      if (in_valid && in_ready) begin
        expected_roots.push_back(predict_root(radicand));
        words_sent++;
        v_n = 0;
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == IDX_DEGREE) degree_sh = cfg_data[DEG_W-1:0];
        else if (cfg_index == IDX_ITER) iters_sh = cfg_data[ITER_W-1:0];
        c_n = 0;
      end
      if (!v_n && !c_n) begin
        if (pause_cnt > 0) begin
          pause_cnt--;
        end else if (pending.size() > 0) begin
          h = pending[0];
          case (h.kind)
            K_DATA: begin
              if (quiet || $urandom_range(99) >= 32) begin
                radicand <= h.val;
                v_n = 1;
                void'(pending.pop_front());
              end
            end
            K_CFG: begin
              cfg_index <= h.idx;
              cfg_data <= h.val;
              c_n = 1;
              void'(pending.pop_front());
            end
            default: begin
              if (expected_roots.size() == 0 && !out_valid) begin
                pause_cnt = 20;
                void'(pending.pop_front());
              end
            end
          endcase
        end
      end
      in_valid <= v_n;
      cfg_valid <= c_n;
    end
  end

  // monitor
  always @(posedge clk) begin
    root_t e;
    logic rdy;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_roots.size() == 0) begin
          $display("%0t: unexpected word root=%h status=%b", $time, root_value, status);
          errors++;
        end else begin
          e = expected_roots.pop_front();
          if (root_value !== e.root) begin
            $display("%0t: root_value expected %h actual %h", $time, e.root, root_value);
            errors++;
          end
          if (status !== e.status) begin
            $display("%0t: status expected %b actual %b", $time, e.status, status);
            errors++;
          end
        end
        results_seen++;
      end
      if (!hold_done && results_seen == 40) begin
        hold_done = 1;
        hold_cnt = 3000;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        rdy = 0;
      end else if (results_seen >= 70 && results_seen < 100) begin
        rdy = 1;
      end else begin
        rdy = $urandom_range(99) >= 32;
      end
      out_ready <= rdy;
    end
  end

  task automatic add_word(logic [31:0] v);
    pending.push_back('{K_DATA, 8'd0, v});
  endtask

  task automatic add_cfg(logic [7:0] i, logic [31:0] v);
    pending.push_back('{K_DRAIN, 8'd0, 32'd0});
    pending.push_back('{K_CFG, i, v});
  endtask

  function automatic logic [31:0] rand_radicand();
    case ($urandom_range(3))
      0: return $urandom();
      1: return $urandom_range(32'hFFFF);
      2: return 32'hFFFF_0000 | $urandom_range(32'hFFFF);
      default: return $urandom() >> $urandom_range(31);
    endcase
  endfunction

  initial begin
    add_word(32'd0);
    add_word(32'd1);
    add_word(ROOT_MAX);
    add_cfg(IDX_DEGREE, 32'd16);
    add_cfg(IDX_ITER, 32'd3);
    add_word(32'd0);
    add_word(32'd1);
    add_word(32'd2);
    add_word(32'h0001_0000);
    add_word(ROOT_MAX);
    add_word(32'h8000_0000);
    add_cfg(IDX_DEGREE, 32'd0);
    add_cfg(IDX_ITER, 32'd0);
    add_word(32'd5);
    add_word(ROOT_MAX);
    add_cfg(IDX_DEGREE, 32'd1);
    add_cfg(IDX_ITER, 32'd127);
    add_word(32'h0004_0000);
    add_cfg(IDX_DEGREE, 32'd31);
    add_cfg(IDX_ITER, 32'd2);
    add_cfg(IDX_UNUSED, 32'd9);
    add_word(32'h1234_5678);
    add_word(32'd3);
    add_cfg(IDX_DEGREE, 32'd17);
    add_cfg(IDX_ITER, 32'd100);
    add_word(ROOT_MAX);
    for (int b = 0; b < 15; b++) begin
      add_cfg(IDX_DEGREE, $urandom_range(31));
      add_cfg(IDX_ITER, $urandom_range(9) == 0 ? 32'd0 : $urandom_range(1, 8));
      for (int i = 0; i < 10; i++) add_word(rand_radicand());
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    do @(posedge clk);
    while (pending.size() != 0 || in_valid || cfg_valid || expected_roots.size() != 0);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end
endmodule
